// ===== hdl/tdfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table-driven FSM engine package
// Table and log sizes, field widths, action codes, table entry layout and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tdfe_pkg;

  localparam int MAX_TRANSITIONS = 512;
  localparam int HISTORY_DEPTH   = 1024;

  localparam int ACT_W    = 3;
  localparam int STATE_W  = 6;
  localparam int EVENT_W  = 8;
  localparam int HIDX_W   = $clog2(HISTORY_DEPTH);
  localparam int TIDX_W   = $clog2(MAX_TRANSITIONS);
  localparam int HLEN_W   = $clog2(HISTORY_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FIRE     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CAN_FIRE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd4;

  typedef struct packed {
    logic [STATE_W-1:0] src;
    logic [EVENT_W-1:0] evt;
    logic [STATE_W-1:0] dst;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic scan_done;
    logic exec;
    logic hist_rd;
    logic hist_done;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/tdfe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table-driven FSM engine controller
// Sequences each transaction: table scan, history read or table or start-state
// update, and raises the one-cycle done strobe.
// ----------------------------------------------------------------------------
module tdfe_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [tdfe_pkg::ACT_W-1:0] action_i,
  input  wire tdfe_pkg::status_t          status_i,
  output tdfe_pkg::cmd_t                  cmd_o,
  output logic                            busy_o,
  output logic                            done_o
);
  import tdfe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_HRD  = 5'b01000,
    S_HOUT = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (action_i)
            ACT_FIRE, ACT_CAN_FIRE: state_d = S_SCAN;
            ACT_READ:               state_d = S_HRD;
            default:                state_d = S_EXEC;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit || status_i.exhausted) begin
          cmd_o.scan_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      S_HRD: begin
        cmd_o.hist_rd = 1'b1;
        state_d       = S_HOUT;
      end
      S_HOUT: begin
        cmd_o.hist_done = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign done_d = cmd_o.exec || cmd_o.scan_done || cmd_o.hist_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== hdl/tdfe_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table-driven FSM engine datapath
// Transition table and history memories, counters, present state, scan
// pipeline and result registers.
// ----------------------------------------------------------------------------
module tdfe_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tdfe_pkg::cmd_t               cmd_i,
  output tdfe_pkg::status_t                 status_o,
  input  wire logic [tdfe_pkg::ACT_W-1:0]   action_i,
  input  wire logic [tdfe_pkg::STATE_W-1:0] from_state_i,
  input  wire logic [tdfe_pkg::EVENT_W-1:0] event_code_i,
  input  wire logic [tdfe_pkg::STATE_W-1:0] to_state_i,
  input  wire logic [tdfe_pkg::HIDX_W-1:0]  history_index_i,
  output logic                              matched_o,
  output logic [tdfe_pkg::TIDX_W-1:0]       transition_index_o,
  output logic [tdfe_pkg::STATE_W-1:0]      current_state_o,
  output logic                              table_full_o,
  output logic [tdfe_pkg::STATE_W-1:0]      history_value_o,
  output logic                              history_valid_o,
  output logic [tdfe_pkg::HLEN_W-1:0]       history_length_o
);
  import tdfe_pkg::*;

  localparam int TAW  = $clog2(MAX_TRANSITIONS);
  localparam int TCW  = $clog2(MAX_TRANSITIONS + 1);
  localparam int HAW  = $clog2(HISTORY_DEPTH);
  localparam int HLW  = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPW = (HLW > HIDX_W) ? HLW : HIDX_W;

  // memories
  entry_t             tbl_mem [MAX_TRANSITIONS];
  logic [STATE_W-1:0] hist_mem [HISTORY_DEPTH];

  // latched transaction
  logic [ACT_W-1:0]   act_q;
  logic [STATE_W-1:0] from_q;
  logic [EVENT_W-1:0] evt_q;
  logic [STATE_W-1:0] to_q;
  logic [HIDX_W-1:0]  hidx_q;

  // control state
  logic [TCW-1:0]     count_q, count_d;
  logic [STATE_W-1:0] present_q, present_d;
  logic [HLW-1:0]     logged_q, logged_d;
  logic [TCW-1:0]     ptr_q, ptr_d;
  logic               rvalid_q, rvalid_d;

  // scan and result payload
  logic [TAW-1:0]     ridx_q;
  entry_t             tbl_rdata_q;
  logic [STATE_W-1:0] hist_rdata_q;
  logic               matched_q, matched_d;
  logic [TIDX_W-1:0]  tindex_q, tindex_d;
  logic               full_q, full_d;
  logic [STATE_W-1:0] hval_q, hval_d;
  logic               hvalid_q, hvalid_d;

  // memory ports
  logic               tbl_we, tbl_re;
  logic               hist_we, hist_re;
  logic [HAW-1:0]     hist_waddr;
  logic [STATE_W-1:0] hist_wdata;

  logic               hit, exhausted, more, table_room, log_room, in_range;

  assign more       = (ptr_q < count_q);
  assign table_room = (count_q < TCW'(MAX_TRANSITIONS));
  assign log_room   = (logged_q < HLW'(HISTORY_DEPTH));
  assign hit        = rvalid_q && (tbl_rdata_q.src == present_q) && (tbl_rdata_q.evt == evt_q);
  assign exhausted  = !rvalid_q && !more;
  assign in_range   = (CMPW'(hidx_q) < CMPW'(logged_q)) &&
                      (CMPW'(hidx_q) < CMPW'(HISTORY_DEPTH));

  assign status_o.hit       = hit;
  assign status_o.exhausted = exhausted;

  always_comb begin
    count_d    = count_q;
    present_d  = present_q;
    logged_d   = logged_q;
    ptr_d      = ptr_q;
    rvalid_d   = rvalid_q;
    matched_d  = matched_q;
    tindex_d   = tindex_q;
    full_d     = full_q;
    hval_d     = hval_q;
    hvalid_d   = hvalid_q;
    tbl_we     = 1'b0;
    tbl_re     = cmd_i.scan && more;
    hist_we    = 1'b0;
    hist_re    = cmd_i.hist_rd;
    hist_waddr = '0;
    hist_wdata = from_q;

    if (cmd_i.load) begin
      ptr_d    = '0;
      rvalid_d = 1'b0;
    end else if (cmd_i.scan) begin
      rvalid_d = tbl_re;
      if (tbl_re) begin
        ptr_d = ptr_q + TCW'(1);
      end
    end

    if (cmd_i.exec) begin
      matched_d = 1'b0;
      tindex_d  = '0;
      hval_d    = '0;
      hvalid_d  = 1'b0;
      full_d    = (act_q == ACT_ADD) && !table_room;
      if ((act_q == ACT_ADD) && table_room) begin
        tbl_we  = 1'b1;
        count_d = count_q + TCW'(1);
      end
      if (act_q == ACT_SET) begin
        present_d  = from_q;
        hist_we    = 1'b1;
        hist_waddr = '0;
        hist_wdata = from_q;
        logged_d   = HLW'(1);
      end
    end

    if (cmd_i.scan_done) begin
      matched_d = hit;
      tindex_d  = hit ? TIDX_W'(ridx_q) : '0;
      full_d    = 1'b0;
      hval_d    = '0;
      hvalid_d  = 1'b0;
      if (hit && (act_q == ACT_FIRE)) begin
        present_d = tbl_rdata_q.dst;
        if (log_room) begin
          hist_we    = 1'b1;
          hist_waddr = logged_q[HAW-1:0];
          hist_wdata = tbl_rdata_q.dst;
          logged_d   = logged_q + HLW'(1);
        end
      end
    end

    if (cmd_i.hist_done) begin
      matched_d = 1'b0;
      tindex_d  = '0;
      full_d    = 1'b0;
      hvalid_d  = in_range;
      hval_d    = in_range ? hist_rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      present_q <= '0;
      logged_q  <= '0;
      ptr_q     <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      count_q   <= count_d;
      present_q <= present_d;
      logged_q  <= logged_d;
      ptr_q     <= ptr_d;
      rvalid_q  <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      from_q <= from_state_i;
      evt_q  <= event_code_i;
      to_q   <= to_state_i;
      hidx_q <= history_index_i;
    end
    if (tbl_re) begin
      ridx_q <= ptr_q[TAW-1:0];
    end
    matched_q <= matched_d;
    tindex_q  <= tindex_d;
    full_q    <= full_d;
    hval_q    <= hval_d;
    hvalid_q  <= hvalid_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[count_q[TAW-1:0]] <= '{src: from_q, evt: evt_q, dst: to_q};
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[ptr_q[TAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rdata_q <= hist_mem[HAW'(hidx_q)];
    end
  end

  assign matched_o          = matched_q;
  assign transition_index_o = tindex_q;
  assign current_state_o    = present_q;
  assign table_full_o       = full_q;
  assign history_value_o    = hval_q;
  assign history_valid_o    = hvalid_q;
  assign history_length_o   = HLEN_W'(logged_q);

endmodule
`default_nettype wire

// ===== hdl/table_driven_fsm_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table-driven FSM engine
// A transaction is taken when start_i is high while busy_o is low. Its result
// appears on the result ports, marked by done_o; the receiver cannot stall
// it, so capture it in that cycle. busy_o drops in the done cycle, so the next
// transaction can start there. Add, set start state and unknown actions are
// done in the update state. A history read first does the registered read of
// the history memory. Fire and can-fire scan the transition table through its
// single read port, one entry per cycle. The scan stops at the first matching
// entry, or once all C stored transitions (C at most MAX_TRANSITIONS) have
// been read without a match; on an empty table it reads no entry.
// ----------------------------------------------------------------------------
module table_driven_fsm_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [tdfe_pkg::ACT_W-1:0]   action_i,
  input  wire logic [tdfe_pkg::STATE_W-1:0] from_state_i,
  input  wire logic [tdfe_pkg::EVENT_W-1:0] event_code_i,
  input  wire logic [tdfe_pkg::STATE_W-1:0] to_state_i,
  input  wire logic [tdfe_pkg::HIDX_W-1:0]  history_index_i,
  output logic                              done_o,
  output logic                              matched_o,
  output logic [tdfe_pkg::TIDX_W-1:0]       transition_index_o,
  output logic [tdfe_pkg::STATE_W-1:0]      current_state_o,
  output logic                              table_full_o,
  output logic [tdfe_pkg::STATE_W-1:0]      history_value_o,
  output logic                              history_valid_o,
  output logic [tdfe_pkg::HLEN_W-1:0]       history_length_o
);
  import tdfe_pkg::*;

  cmd_t    cmd;
  status_t status;

  tdfe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  tdfe_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .action_i           (action_i),
    .from_state_i       (from_state_i),
    .event_code_i       (event_code_i),
    .to_state_i         (to_state_i),
    .history_index_i    (history_index_i),
    .matched_o          (matched_o),
    .transition_index_o (transition_index_o),
    .current_state_o    (current_state_o),
    .table_full_o       (table_full_o),
    .history_value_o    (history_value_o),
    .history_valid_o    (history_valid_o),
    .history_length_o   (history_length_o)
  );

endmodule
`default_nettype wire

// ===== tb/tdfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table-driven FSM engine checker
// Watches the command and result ports of the engine. Every command taken in
// is run through a local model of the transition table, present state and
// visited-state log, and the outcome is queued. Each result strobe is compared
// field by field with the oldest queued outcome. Mismatches are counted.
// ----------------------------------------------------------------------------
module tdfe_checker #(
  parameter int MAX_TRANSITIONS = 512,
  parameter int HISTORY_DEPTH   = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [tdfe_pkg::ACT_W-1:0]    action_i,
  input  logic [tdfe_pkg::STATE_W-1:0]  from_state_i,
  input  logic [tdfe_pkg::EVENT_W-1:0]  event_code_i,
  input  logic [tdfe_pkg::STATE_W-1:0]  to_state_i,
  input  logic [tdfe_pkg::HIDX_W-1:0]   history_index_i,
  input  logic                          done_i,
  input  logic                          matched_i,
  input  logic [tdfe_pkg::TIDX_W-1:0]   transition_index_i,
  input  logic [tdfe_pkg::STATE_W-1:0]  current_state_i,
  input  logic                          table_full_i,
  input  logic [tdfe_pkg::STATE_W-1:0]  history_value_i,
  input  logic                          history_valid_i,
  input  logic [tdfe_pkg::HLEN_W-1:0]   history_length_i,
  output int                            fails_o,
  output int                            outstanding_o,
  output int                            checked_o,
  output int                            hits_o,
  output int                            drops_o,
  output int                            capped_o
);

  typedef struct packed {
    logic                         matched;
    logic [tdfe_pkg::TIDX_W-1:0]  tidx;
    logic [tdfe_pkg::STATE_W-1:0] cur;
    logic                         full;
    logic [tdfe_pkg::STATE_W-1:0] hval;
    logic                         hvalid;
    logic [tdfe_pkg::HLEN_W-1:0]  hlen;
  } outcome_t;

  tdfe_pkg::entry_t             rules[MAX_TRANSITIONS];
  int                           rule_count;
  logic [tdfe_pkg::STATE_W-1:0] fsm_state;
  logic [tdfe_pkg::STATE_W-1:0] visited[HISTORY_DEPTH];
  int                           visit_count;
  outcome_t                     outcomes[$];

  initial begin
    fails_o       = 0;
    outstanding_o = 0;
    checked_o     = 0;
    hits_o        = 0;
    drops_o       = 0;
    capped_o      = 0;
    rule_count    = 0;
    fsm_state     = '0;
    visit_count   = 0;
  end

  task automatic flag_mismatch(string msg);
    $display("[%0t] %s: %s", $realtime, "tdfe_checker", msg);
    fails_o++;
  endtask

  function automatic int first_hit(logic [tdfe_pkg::EVENT_W-1:0] ev);
    for (int i = 0; i < rule_count; i++) begin
      if (rules[i].src == fsm_state && rules[i].evt == ev) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t step_engine(
    logic [tdfe_pkg::ACT_W-1:0]   act,
    logic [tdfe_pkg::STATE_W-1:0] src_s,
    logic [tdfe_pkg::EVENT_W-1:0] ev,
    logic [tdfe_pkg::STATE_W-1:0] dst_s,
    logic [tdfe_pkg::HIDX_W-1:0]  hidx
  );
    outcome_t o;
    int       at;
    o = '0;
    case (act)
      tdfe_pkg::ACT_ADD: begin
        if (rule_count >= MAX_TRANSITIONS) begin
          o.full = 1'b1;
          drops_o++;
        end else begin
          rules[rule_count].src = src_s;
          rules[rule_count].evt = ev;
          rules[rule_count].dst = dst_s;
          rule_count++;
        end
      end
      tdfe_pkg::ACT_FIRE: begin
        at = first_hit(ev);
        if (at >= 0) begin
          o.matched = 1'b1;
          o.tidx    = at[tdfe_pkg::TIDX_W-1:0];
          fsm_state = rules[at].dst;
          hits_o++;
          if (visit_count < HISTORY_DEPTH) begin
            visited[visit_count] = fsm_state;
            visit_count++;
          end else begin
            capped_o++;
          end
        end
      end
      tdfe_pkg::ACT_CAN_FIRE: begin
        at = first_hit(ev);
        if (at >= 0) begin
          o.matched = 1'b1;
          o.tidx    = at[tdfe_pkg::TIDX_W-1:0];
        end
      end
      tdfe_pkg::ACT_SET: begin
        fsm_state   = src_s;
        visited[0]  = src_s;
        visit_count = 1;
      end
      tdfe_pkg::ACT_READ: begin
        if (int'(hidx) < visit_count) begin
          o.hvalid = 1'b1;
          o.hval   = visited[hidx];
        end
      end
      default: ;
    endcase
    o.cur  = fsm_state;
    o.hlen = visit_count[tdfe_pkg::HLEN_W-1:0];
    return o;
  endfunction

  always @(posedge clk_i) begin : watch
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      rule_count  = 0;
      fsm_state   = '0;
      visit_count = 0;
      outcomes.delete();
    end else begin
      if (done_i) begin
        got = '{matched_i, transition_index_i, current_state_i, table_full_i,
                history_value_i, history_valid_i, history_length_i};
        if (outcomes.size() == 0) begin
          flag_mismatch("result strobe with no transaction pending");
        end else begin
          want = outcomes.pop_front();
          checked_o++;
          if (got.matched !== want.matched)
            flag_mismatch($sformatf("matched %0b, expected %0b", got.matched, want.matched));
          if (got.tidx !== want.tidx)
            flag_mismatch($sformatf("transition_index %0d, expected %0d", got.tidx, want.tidx));
          if (got.cur !== want.cur)
            flag_mismatch($sformatf("current_state %0d, expected %0d", got.cur, want.cur));
          if (got.full !== want.full)
            flag_mismatch($sformatf("table_full %0b, expected %0b", got.full, want.full));
          if (got.hval !== want.hval)
            flag_mismatch($sformatf("history_value %0d, expected %0d", got.hval, want.hval));
          if (got.hvalid !== want.hvalid)
            flag_mismatch($sformatf("history_valid %0b, expected %0b", got.hvalid, want.hvalid));
          if (got.hlen !== want.hlen)
            flag_mismatch($sformatf("history_length %0d, expected %0d", got.hlen, want.hlen));
        end
      end
      if (start_i && !busy_i) begin
        outcomes.push_back(step_engine(action_i, from_state_i, event_code_i, to_state_i,
                                       history_index_i));
      end
    end
    outstanding_o = outcomes.size();
  end

endmodule

// ===== tb/tb_table_driven_fsm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table-driven FSM engine testbench
// Drives directed and random command transactions into the engine with random
// gaps, fills the transition table past capacity, walks the state machine
// inside a small pool and leaves all checking to the checker beside the engine.
// ----------------------------------------------------------------------------
module tb_table_driven_fsm_engine;

  localparam int MAX_TRANSITIONS = tdfe_pkg::MAX_TRANSITIONS;
  localparam int HISTORY_DEPTH   = tdfe_pkg::HISTORY_DEPTH;
  localparam int POOL_STATES     = 4;
  localparam int POOL_EVENTS     = 4;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int TOTAL_ITEMS     = 1170;

  logic                          clk_i  = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_r = 1'b0;
  logic [tdfe_pkg::ACT_W-1:0]    action_r = '0;
  logic [tdfe_pkg::STATE_W-1:0]  from_r = '0;
  logic [tdfe_pkg::EVENT_W-1:0]  event_r = '0;
  logic [tdfe_pkg::STATE_W-1:0]  to_r = '0;
  logic [tdfe_pkg::HIDX_W-1:0]   hidx_r = '0;

  logic                          busy;
  logic                          done;
  logic                          matched;
  logic [tdfe_pkg::TIDX_W-1:0]   transition_index;
  logic [tdfe_pkg::STATE_W-1:0]  current_state;
  logic                          table_full;
  logic [tdfe_pkg::STATE_W-1:0]  history_value;
  logic                          history_valid;
  logic [tdfe_pkg::HLEN_W-1:0]   history_length;

  int fails;
  int outstanding;
  int checked;
  int hits;
  int drops;
  int capped;

  int sent        = 0;
  int adds_sent   = 0;
  int calm_left   = 0;
  int stall_count = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  table_driven_fsm_engine dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_r),
    .busy_o            (busy),
    .action_i          (action_r),
    .from_state_i      (from_r),
    .event_code_i      (event_r),
    .to_state_i        (to_r),
    .history_index_i   (hidx_r),
    .done_o            (done),
    .matched_o         (matched),
    .transition_index_o(transition_index),
    .current_state_o   (current_state),
    .table_full_o      (table_full),
    .history_value_o   (history_value),
    .history_valid_o   (history_valid),
    .history_length_o  (history_length)
  );

  tdfe_checker #(
    .MAX_TRANSITIONS(MAX_TRANSITIONS),
    .HISTORY_DEPTH  (HISTORY_DEPTH)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_r),
    .busy_i            (busy),
    .action_i          (action_r),
    .from_state_i      (from_r),
    .event_code_i      (event_r),
    .to_state_i        (to_r),
    .history_index_i   (hidx_r),
    .done_i            (done),
    .matched_i         (matched),
    .transition_index_i(transition_index),
    .current_state_i   (current_state),
    .table_full_i      (table_full),
    .history_value_i   (history_value),
    .history_valid_i   (history_valid),
    .history_length_i  (history_length),
    .fails_o           (fails),
    .outstanding_o     (outstanding),
    .checked_o         (checked),
    .hits_o            (hits),
    .drops_o           (drops),
    .capped_o          (capped)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start_r && !busy) || done) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("table_driven_fsm_engine: mismatch");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(logic [tdfe_pkg::ACT_W-1:0] act, int src_s, int ev, int dst_s,
                       int hidx);
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      start_r <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_r  <= 1'b1;
    action_r <= act;
    from_r   <= src_s[tdfe_pkg::STATE_W-1:0];
    event_r  <= ev[tdfe_pkg::EVENT_W-1:0];
    to_r     <= dst_s[tdfe_pkg::STATE_W-1:0];
    hidx_r   <= hidx[tdfe_pkg::HIDX_W-1:0];
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if (act == tdfe_pkg::ACT_ADD) adds_sent++;
  endtask

  function automatic int any_state();
    return $urandom_range(0, 63);
  endfunction

  function automatic int any_event();
    return $urandom_range(0, 255);
  endfunction

  function automatic int any_index();
    return $urandom_range(0, 1023);
  endfunction

  function automatic logic [tdfe_pkg::ACT_W-1:0] unknown_action();
    int code;
    code = int'(tdfe_pkg::ACT_READ) + int'($urandom_range(1, 3));
    return code[tdfe_pkg::ACT_W-1:0];
  endfunction

  task automatic add_random_rule();
    int src_s;
    int ev;
    int dst_s;
    case ($urandom_range(0, 2))
      0: begin
        src_s = $urandom_range(0, POOL_STATES - 1);
        ev    = $urandom_range(0, POOL_EVENTS - 1);
        dst_s = $urandom_range(0, POOL_STATES - 1);
      end
      1: begin
        src_s = $urandom_range(POOL_STATES, 63);
        ev    = any_event();
        dst_s = any_state();
      end
      default: begin
        src_s = $urandom_range(0, POOL_STATES - 1);
        ev    = $urandom_range(POOL_EVENTS, 255);
        dst_s = any_state();
      end
    endcase
    issue(tdfe_pkg::ACT_ADD, src_s, ev, dst_s, any_index());
  endtask

  task automatic read_random();
    int hidx;
    case ($urandom_range(0, 3))
      0:       hidx = $urandom_range(0, 31);
      1:       hidx = $urandom_range(1000, 1023);
      default: hidx = any_index();
    endcase
    issue(tdfe_pkg::ACT_READ, any_state(), any_event(), any_state(), hidx);
  endtask

  initial begin
    int r;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table and empty log
    issue(tdfe_pkg::ACT_READ, 0, 0, 0, 0);
    issue(tdfe_pkg::ACT_READ, 63, 255, 63, 1023);
    issue(tdfe_pkg::ACT_FIRE, 0, 0, 0, 0);
    issue(tdfe_pkg::ACT_CAN_FIRE, 63, 255, 63, 1023);
    issue(tdfe_pkg::ACT_ADD, 0, 255, 63, 0);
    issue(tdfe_pkg::ACT_ADD, 63, 0, 0, 1023);
    issue(tdfe_pkg::ACT_ADD, 63, 255, 63, 0);
    issue(tdfe_pkg::ACT_ADD, 0, 0, 0, 0);
    issue(tdfe_pkg::ACT_CAN_FIRE, 0, 255, 0, 0);
    // fire before any start state is set
    issue(tdfe_pkg::ACT_FIRE, 0, 255, 0, 0);
    issue(tdfe_pkg::ACT_READ, 0, 0, 0, 0);
    issue(tdfe_pkg::ACT_READ, 0, 0, 0, 1);
    issue(tdfe_pkg::ACT_FIRE, 0, 0, 0, 0);
    issue(tdfe_pkg::ACT_FIRE, 0, 7, 0, 0);
    issue(tdfe_pkg::ACT_CAN_FIRE, 0, 7, 0, 0);
    issue(tdfe_pkg::ACT_READ + 3'd1, 63, 255, 63, 1023);
    issue(tdfe_pkg::ACT_READ + 3'd2, 0, 0, 0, 0);
    issue(tdfe_pkg::ACT_READ + 3'd3, 63, 255, 63, 1023);
    issue(tdfe_pkg::ACT_SET, 63, 0, 0, 0);
    issue(tdfe_pkg::ACT_FIRE, 0, 255, 0, 0);
    issue(tdfe_pkg::ACT_READ, 0, 0, 0, 1);
    issue(tdfe_pkg::ACT_SET, 0, 255, 63, 1023);
    issue(tdfe_pkg::ACT_READ, 0, 0, 0, 1023);

    // every pool state answers every pool event, staying inside the pool
    for (int s = 0; s < POOL_STATES; s++) begin
      for (int e = 0; e < POOL_EVENTS; e++) begin
        issue(tdfe_pkg::ACT_ADD, s, e, $urandom_range(0, POOL_STATES - 1), any_index());
      end
    end

    // mixed traffic until the table overflows
    while (adds_sent < MAX_TRANSITIONS + 30) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_random_rule();
      end else if (r < 82) begin
        issue(tdfe_pkg::ACT_FIRE, any_state(),
              ($urandom_range(0, 9) < 7) ? $urandom_range(0, POOL_EVENTS - 1) : any_event(),
              any_state(), any_index());
      end else if (r < 88) begin
        issue(tdfe_pkg::ACT_CAN_FIRE, any_state(),
              ($urandom_range(0, 1) == 0) ? $urandom_range(0, POOL_EVENTS - 1) : any_event(),
              any_state(), any_index());
      end else if (r < 94) begin
        read_random();
      end else if (r < 98) begin
        issue(tdfe_pkg::ACT_SET,
              ($urandom_range(0, 1) == 0) ? $urandom_range(0, POOL_STATES - 1) : any_state(),
              any_event(), any_state(), any_index());
      end else begin
        issue(unknown_action(), any_state(), any_event(), any_state(), any_index());
      end
    end

    // long walk inside the pool
    issue(tdfe_pkg::ACT_SET, $urandom_range(0, POOL_STATES - 1), any_event(), any_state(),
          any_index());
    while (sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        issue(tdfe_pkg::ACT_FIRE, any_state(), $urandom_range(0, POOL_EVENTS - 1),
              any_state(), any_index());
      end else if (r < 93) begin
        issue(tdfe_pkg::ACT_CAN_FIRE, any_state(), any_event(), any_state(), any_index());
      end else if (r < 98) begin
        read_random();
      end else if (r < 99) begin
        add_random_rule();
      end else begin
        issue(unknown_action(), any_state(), any_event(), any_state(), any_index());
      end
    end

    start_r <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d transactions (%0d results checked, %0d adds)", sent, checked,
             adds_sent);
    $display("%0d fires moved, %0d adds dropped on a full table, %0d moves past a full log",
             hits, drops, capped);
    if (fails == 0) begin
      $display("table_driven_fsm_engine: match");
    end else begin
      $display("table_driven_fsm_engine: mismatch");
    end
    $finish;
  end

endmodule
